// ===== sv/sse_pkg.sv =====
// Shared types, constants and helpers for the sorted set engine.
// Used by sse_cell, sse_or_tree and sorted_set_engine; depends on nothing.

package sse_pkg;

    localparam int KEY_W            = 16;
    localparam int CMD_W            = 2;
    localparam int DEFAULT_CAPACITY = 1024;
    localparam int TREE_FAN         = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_MEMBER = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    // Broadcast control from the sequencer to every cell of the row.
    typedef struct packed {
        logic             cmp_en;
        logic             ins_en;
        logic             del_en;
        logic [KEY_W-1:0] key;
    } t_cell_ctrl;

    // Number of registered levels of a TREE_FAN-wide OR tree over n inputs.
    function automatic int tree_levels(input int n);
        int lvl;
        int span;
        lvl  = 0;
        span = 1;
        while (span < n) begin
            span = span * TREE_FAN;
            lvl++;
        end
        if (lvl == 0) begin
            lvl = 1;
        end
        return lvl;
    endfunction

endpackage

// ===== sv/sse_cell.sv =====
// One slot of the sorted key row: holds a key, compares it with the
// broadcast key and shifts toward either neighbor. Depends on sse_pkg.

module sse_cell #(
    parameter int INDEX    = 0,
    parameter int CAPACITY = sse_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  sse_pkg::t_cell_ctrl      i_ctrl,
    input  logic [CNT_W-1:0]         i_count,
    input  logic [sse_pkg::KEY_W-1:0] i_left_key,
    input  logic                     i_left_lt,
    input  logic [sse_pkg::KEY_W-1:0] i_right_key,
    output logic [sse_pkg::KEY_W-1:0] o_key,
    output logic                     o_lt,
    output logic                     o_eq
);

    logic [sse_pkg::KEY_W-1:0] r_key;
    logic                      r_lt;
    logic                      r_eq;
    logic                      w_valid;

    // The slot holds a live key only below the fill count.
    assign w_valid = CNT_W'(INDEX) < i_count;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_lt <= w_valid && (r_key < i_ctrl.key);
            r_eq <= w_valid && (r_key == i_ctrl.key);
        end
        // Slots below the search position keep their key; the others make room
        // for an insert or close the gap of a delete.
        if (i_ctrl.ins_en && !r_lt) begin
            r_key <= i_left_lt ? i_ctrl.key : i_left_key;
        end else if (i_ctrl.del_en && !r_lt) begin
            r_key <= i_right_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

// ===== sv/sse_or_tree.sv =====
// Registered OR reduction of the per-slot match flags, with a register at every level.
// Depends on sse_pkg for the fan-in and the level count.

module sse_or_tree #(
    parameter int WIDTH  = sse_pkg::DEFAULT_CAPACITY,
    parameter int LEVELS = sse_pkg::tree_levels(WIDTH)
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_bits,
    output logic             o_any
);

    logic [WIDTH-1:0] r_lvl [LEVELS+1];
    logic [WIDTH-1:0] n_lvl [LEVELS+1];

    always_comb begin
        n_lvl[0] = i_bits;
        for (int l = 1; l <= LEVELS; l++) begin
            n_lvl[l] = '0;
            for (int j = 0; j < WIDTH; j++) begin
                for (int k = 0; k < sse_pkg::TREE_FAN; k++) begin
                    if (j * sse_pkg::TREE_FAN + k < WIDTH) begin
                        // The first level reduces the live input directly.
                        if (l == 1) begin
                            n_lvl[l][j] = n_lvl[l][j]
                                        | n_lvl[0][j * sse_pkg::TREE_FAN + k];
                        end else begin
                            n_lvl[l][j] = n_lvl[l][j]
                                        | r_lvl[l-1][j * sse_pkg::TREE_FAN + k];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl[0] <= '0;
        for (int l = 1; l <= LEVELS; l++) begin
            r_lvl[l] <= n_lvl[l];
        end
    end

    // Level zero is the live input; its register copy is not read.
    always_comb begin
        o_any = r_lvl[LEVELS][0];
    end

    logic w_unused;
    assign w_unused = |r_lvl[0] | |n_lvl[0];

endmodule

// ===== sv/sorted_set_engine.sv =====
// Top level of the sorted set engine: command sequencer, fill count, result
// register, a row of sse_cell slots and the sse_or_tree match reduction.
// Depends on sse_pkg, sse_cell and sse_or_tree.
//
// Usage. Each input beat on the s_axis channel carries a command in tuser
// (member, insert or delete) and a 16-bit key in tdata. Every beat causes
// exactly one output beat on m_axis, whose tdata carries success in bit 0
// and store_full in bit 1. Command code 3 leaves the store alone and
// answers with both flags clear.
// The keys live in a row of CAPACITY slots kept in ascending order. All slots
// compare the key in parallel, the match flags are reduced through a
// registered OR tree of LEVELS = ceil(log8(CAPACITY)) levels, and then each
// slot either keeps its key or takes the key of a neighbor.
// One beat is in work at a time: the next input beat is taken only once the
// sequencer is back in S_IDLE after S_APPLY. Between acceptance and its result
// beat an item passes S_CMP, S_TREE and S_APPLY in that order; the time spent
// in S_TREE follows the OR tree depth.
// A finished result waits in an output register, so the next input beat is
// taken while the receiver stalls; that next item then holds at its final
// step until the output register is free.
// Reset clears the fill count and the handshake state; slot contents are not
// cleared, since slots at or above the count are never looked at.

module sorted_set_engine #(
    parameter int CAPACITY = sse_pkg::DEFAULT_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] key_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] success, [1] store_full, [7:2] zero
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LEVELS = sse_pkg::tree_levels(CAPACITY);
    localparam int LVL_W  = $clog2(LEVELS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_TREE,
        S_APPLY
    } t_state;

    t_state                    r_state, n_state;
    sse_pkg::t_cmd             r_cmd, n_cmd;
    logic [sse_pkg::KEY_W-1:0] r_key, n_key;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [LVL_W-1:0]          r_wait, n_wait;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_success, n_out_success;
    logic                      r_out_full, n_out_full;

    sse_pkg::t_cell_ctrl       w_ctrl;
    logic                      w_present;
    logic                      w_store_full;
    logic                      w_out_free;
    logic                      w_accept;
    logic [sse_pkg::KEY_W-1:0] w_key [CAPACITY];
    logic [CAPACITY-1:0]       w_lt;
    logic [CAPACITY-1:0]       w_eq;

    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_store_full = r_count >= CNT_W'(CAPACITY);

    // Sequencer: capture, compare, reduce the match flags, then apply.
    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_key         = r_key;
        n_count       = r_count;
        n_wait        = r_wait;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_success = r_out_success;
        n_out_full    = r_out_full;
        w_ctrl.cmp_en = 1'b0;
        w_ctrl.ins_en = 1'b0;
        w_ctrl.del_en = 1'b0;
        w_ctrl.key    = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = sse_pkg::t_cmd'(s_axis_tuser);
                    n_key   = s_axis_tdata;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctrl.cmp_en = 1'b1;
                n_wait        = LVL_W'(LEVELS - 1);
                n_state       = S_TREE;
            end
            S_TREE: begin
                if (r_wait == '0) begin
                    n_state = S_APPLY;
                end else begin
                    n_wait = r_wait - 1'b1;
                end
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_success = 1'b0;
                    n_out_full    = 1'b0;
                    n_state       = S_IDLE;
                    unique case (r_cmd)
                        sse_pkg::CMD_MEMBER: begin
                            n_out_success = w_present;
                        end
                        sse_pkg::CMD_INSERT: begin
                            if (!w_present) begin
                                if (w_store_full) begin
                                    n_out_full = 1'b1;
                                end else begin
                                    w_ctrl.ins_en = 1'b1;
                                    n_count       = r_count + 1'b1;
                                    n_out_success = 1'b1;
                                end
                            end
                        end
                        sse_pkg::CMD_DELETE: begin
                            if (w_present) begin
                                w_ctrl.del_en = 1'b1;
                                n_count       = r_count - 1'b1;
                                n_out_success = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
        r_cmd         <= n_cmd;
        r_key         <= n_key;
        r_out_success <= n_out_success;
        r_out_full    <= n_out_full;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_full, r_out_success};

    // Row of slots. The first slot sees a virtual left neighbor that is below
    // every key, the last slot keeps its own key when a delete closes a gap.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [sse_pkg::KEY_W-1:0] w_left_key;
        logic                      w_left_lt;
        logic [sse_pkg::KEY_W-1:0] w_right_key;

        if (i == 0) begin : g_first
            assign w_left_key = '0;
            assign w_left_lt  = 1'b1;
        end else begin : g_inner
            assign w_left_key = w_key[i-1];
            assign w_left_lt  = w_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_right_key = w_key[i];
        end else begin : g_body
            assign w_right_key = w_key[i+1];
        end

        sse_cell #(
            .INDEX   (i),
            .CAPACITY(CAPACITY),
            .CNT_W   (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_count    (r_count),
            .i_left_key (w_left_key),
            .i_left_lt  (w_left_lt),
            .i_right_key(w_right_key),
            .o_key      (w_key[i]),
            .o_lt       (w_lt[i]),
            .o_eq       (w_eq[i])
        );
    end

    // The match flags of all slots reduce to one presence bit by S_APPLY.
    sse_or_tree #(
        .WIDTH (CAPACITY),
        .LEVELS(LEVELS)
    ) u_or_tree (
        .i_clk (i_clk),
        .i_bits(w_eq),
        .o_any (w_present)
    );

    // The fill count never passes the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // A result never reports both success and a refused insert.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_success && r_out_full))
        else $error("success and store_full both set");

    // The count moves by at most one per item, and only when a result is loaded.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_APPLY) |=> $stable(r_count))
        else $error("fill count changed outside the apply step");

    a_count_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |=> (r_count == $past(r_count))
                               || (r_count == $past(r_count) + 1'b1)
                               || (r_count == $past(r_count) - 1'b1))
        else $error("fill count moved by more than one");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for sorted_set_engine: directed rows, then random
// member, insert and delete traffic that fills the store, checked against a predictor.
// Depends on sse_pkg and the sorted_set_engine RTL.

module testbench;

    localparam int          SET_CAP        = sse_pkg::DEFAULT_CAPACITY;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int          DIRECTED_N     = 24;
    localparam int          PHASE_N        = 4;
    localparam int          RAND_PER_PHASE = 494;
    // Up to this many random items the traffic is insert heavy, so that the
    // store runs full well before the end and refused inserts are exercised.
    localparam int          FILL_ITEMS     = 1600;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 32;
    // The longest quiet stretch of a correct run is the receiver hold-off plus
    // the work on one item; long random gaps on both sides stay far below this.
    localparam int          WATCHDOG_LIMIT = 6000;

    typedef struct packed {
        logic store_full;
        logic success;
    } t_set_answer;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [sse_pkg::KEY_W-1:0] key;
        logic                      typed;
        logic                      want_full;
        logic                      want_success;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] key_value
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] success, [1] store_full, [7:2] zero

    // Predictor state: ascending keys, valid below stored_n.
    logic [sse_pkg::KEY_W-1:0] set_keys [SET_CAP];
    int unsigned      stored_n;

    t_set_answer      pending_answers [$];
    int unsigned      error_count;
    int unsigned      quiet_cycles;
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    bit               hold_armed;
    bit               hold_done;

    int unsigned      phase_send_idle  [PHASE_N] = '{0, 80, 0, 31};
    int unsigned      phase_recv_stall [PHASE_N] = '{0, 0, 80, 31};

    // Directed rows. The expected answer is typed in only where it is plain;
    // the other rows take the predictor's answer.
    t_directed_row directed_rows [DIRECTED_N] = '{
        '{sse_pkg::CMD_MEMBER, 16'h0000, 1'b1, 1'b0, 1'b0},   // query on an empty store
        '{sse_pkg::CMD_DELETE, 16'hFFFF, 1'b1, 1'b0, 1'b0},   // delete from an empty store
        '{sse_pkg::CMD_INSERT, 16'h8000, 1'b1, 1'b0, 1'b1},
        '{sse_pkg::CMD_INSERT, 16'h0000, 1'b1, 1'b0, 1'b1},   // lowest key
        '{sse_pkg::CMD_INSERT, 16'hFFFF, 1'b1, 1'b0, 1'b1},   // highest key
        '{sse_pkg::CMD_INSERT, 16'h8000, 1'b1, 1'b0, 1'b0},   // key already present
        '{sse_pkg::CMD_MEMBER, 16'h0000, 1'b1, 1'b0, 1'b1},
        '{sse_pkg::CMD_MEMBER, 16'hFFFF, 1'b1, 1'b0, 1'b1},
        '{sse_pkg::CMD_MEMBER, 16'h7FFF, 1'b1, 1'b0, 1'b0},
        '{CMD_UNUSED,          16'h8000, 1'b1, 1'b0, 1'b0},   // unused command code
        '{CMD_UNUSED,          16'hFFFF, 1'b1, 1'b0, 1'b0},
        '{sse_pkg::CMD_INSERT, 16'h7FFF, 1'b1, 1'b0, 1'b1},
        '{sse_pkg::CMD_INSERT, 16'h8001, 1'b1, 1'b0, 1'b1},
        '{sse_pkg::CMD_DELETE, 16'h8000, 1'b1, 1'b0, 1'b1},   // delete from the middle
        '{sse_pkg::CMD_MEMBER, 16'h8000, 1'b1, 1'b0, 1'b0},
        '{sse_pkg::CMD_MEMBER, 16'h8001, 1'b0, 1'b0, 1'b0},
        '{sse_pkg::CMD_DELETE, 16'h8000, 1'b1, 1'b0, 1'b0},   // key no longer present
        '{sse_pkg::CMD_INSERT, 16'h5555, 1'b0, 1'b0, 1'b0},
        '{sse_pkg::CMD_INSERT, 16'hAAAA, 1'b0, 1'b0, 1'b0},
        '{sse_pkg::CMD_DELETE, 16'h0000, 1'b1, 1'b0, 1'b1},   // delete the first entry
        '{sse_pkg::CMD_DELETE, 16'hFFFF, 1'b1, 1'b0, 1'b1},   // delete the last entry
        '{sse_pkg::CMD_MEMBER, 16'h5555, 1'b0, 1'b0, 1'b0},
        '{sse_pkg::CMD_DELETE, 16'h7FFF, 1'b0, 1'b0, 1'b0},
        '{sse_pkg::CMD_INSERT, 16'h0001, 1'b0, 1'b0, 1'b0}
    };

    sorted_set_engine #(
        .CAPACITY (SET_CAP)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Applies one command to the predicted store and returns its answer.
    function automatic t_set_answer predict_set_op(input logic [1:0] cmd,
                                                   input logic [sse_pkg::KEY_W-1:0] key);
        t_set_answer ans;
        int unsigned pos;
        bit          found;
        ans = '0;
        pos = 0;
        while (pos < stored_n && set_keys[pos] < key) begin
            pos++;
        end
        found = (pos < stored_n) && (set_keys[pos] == key);
        if (cmd == sse_pkg::CMD_MEMBER) begin
            ans.success = found;
        end else if (cmd == sse_pkg::CMD_INSERT && !found) begin
            if (stored_n >= SET_CAP) begin
                ans.store_full = 1'b1;
            end else begin
                for (int i = stored_n; i > pos; i--) begin
                    set_keys[i] = set_keys[i-1];
                end
                set_keys[pos] = key;
                stored_n++;
                ans.success = 1'b1;
            end
        end else if (cmd == sse_pkg::CMD_DELETE && found) begin
            for (int i = pos; i + 1 < stored_n; i++) begin
                set_keys[i] = set_keys[i+1];
            end
            stored_n--;
            ans.success = 1'b1;
        end
        return ans;
    endfunction

    // Picks a key: a stored one with the given odds, otherwise a neighbor of a
    // stored key, an extreme of the range or a fully random key.
    function automatic logic [sse_pkg::KEY_W-1:0] pick_key(input int unsigned present_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (stored_n > 0 && roll < present_pct) begin
            return set_keys[$urandom_range(stored_n - 1)];
        end else if (stored_n > 0 && roll < present_pct + 10) begin
            return set_keys[$urandom_range(stored_n - 1)] + 16'd1;
        end else if (roll < present_pct + 14) begin
            return ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
        end
        return 16'($urandom_range(65535));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("check failed at %0t: %s got %0d want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Offers one beat after a random idle gap, waits for it to be taken and
    // records the answer it should produce.
    task automatic offer_op(input logic [1:0] cmd, input logic [sse_pkg::KEY_W-1:0] key,
                            input bit typed, input t_set_answer typed_ans);
        t_set_answer model_ans;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= key;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        model_ans = predict_set_op(cmd, key);
        pending_answers.push_back(typed ? typed_ans : model_ans);
    endtask

    // Receiver: random stalls, plus one long hold-off when armed so that the
    // result register fills and the block stops taking input beats.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result checker: every result beat is matched against the oldest answer.
    always @(posedge i_clk) begin
        t_set_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_axis_tdata, 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[0] !== want.success) begin
                    report_mismatch("success", m_axis_tdata[0], want.success);
                end
                if (m_axis_tdata[1] !== want.store_full) begin
                    report_mismatch("store_full", m_axis_tdata[1], want.store_full);
                end
                if (m_axis_tdata[7:2] !== 6'd0) begin
                    report_mismatch("padding bits", m_axis_tdata[7:2], 0);
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_set_answer  typed_ans;
        int unsigned  roll;
        int unsigned  item_idx;
        logic [1:0]   cmd;
        logic [sse_pkg::KEY_W-1:0] key;

        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= '0;
        stored_n       = 0;
        error_count    = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b0;
        hold_done      = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A full store is only reached by the random part,
        // since it takes CAPACITY successful inserts.
        for (int r = 0; r < DIRECTED_N; r++) begin
            typed_ans.success    = directed_rows[r].want_success;
            typed_ans.store_full = directed_rows[r].want_full;
            offer_op(directed_rows[r].cmd, directed_rows[r].key,
                     directed_rows[r].typed, typed_ans);
        end

        // Random part: insert-heavy for the first FILL_ITEMS items, so that the
        // store runs full, then a mix that keeps it hovering near capacity.
        item_idx = 0;
        for (int ph = 0; ph < PHASE_N; ph++) begin
            send_idle_pct  = phase_send_idle[ph];
            recv_stall_pct = phase_recv_stall[ph];
            if (ph == 0) begin
                hold_armed = 1'b1;
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (item_idx < FILL_ITEMS) begin
                    if (roll < 85) begin
                        cmd = sse_pkg::CMD_INSERT;
                        key = pick_key(10);
                    end else if (roll < 95) begin
                        cmd = sse_pkg::CMD_MEMBER;
                        key = pick_key(50);
                    end else if (roll < 98) begin
                        cmd = sse_pkg::CMD_DELETE;
                        key = pick_key(70);
                    end else begin
                        cmd = CMD_UNUSED;
                        key = pick_key(30);
                    end
                end else begin
                    if (roll < 35) begin
                        cmd = sse_pkg::CMD_INSERT;
                        key = pick_key(25);
                    end else if (roll < 80) begin
                        cmd = sse_pkg::CMD_DELETE;
                        key = pick_key(70);
                    end else if (roll < 95) begin
                        cmd = sse_pkg::CMD_MEMBER;
                        key = pick_key(50);
                    end else begin
                        cmd = CMD_UNUSED;
                        key = pick_key(30);
                    end
                end
                offer_op(cmd, key, 1'b0, '0);
                item_idx++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_answers.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sse_pkg.sv
sv/sse_cell.sv
sv/sse_or_tree.sv
sv/sorted_set_engine.sv
dv/testbench.sv
